// ===== src/owned_handle_table_macros.svh =====
// Assertion macros used by the handle table top level.
`ifndef OWNED_HANDLE_TABLE_MACROS_SVH
`define OWNED_HANDLE_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OHT_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define OHT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/oht_pkg.sv =====
// Package with types, codes and constants of the owned handle table.
`timescale 1ns / 1ps

package oht_pkg;

    localparam int POOL_SLOTS_DEF = 16;

    localparam logic [30:0] ID_LIMIT = 31'h7FFF_FFFF;
    localparam logic [31:0] NO_OWNER = 32'd0;

    localparam logic [1:0] MODE_CREATE  = 2'd0;
    localparam logic [1:0] MODE_DESTROY = 2'd1;
    localparam logic [1:0] MODE_GET     = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_REFUSED = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_NULL    = 3'd4;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] requester_pid;
        logic [30:0]        handle_id;
        logic signed [31:0] guest_pid;
        logic [31:0]        mem_ref;
    } oht_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] issued_id;
        logic [31:0] found_mem_ref;
    } oht_rsp_t;

    // Request token walking down the row of slot cells.
    typedef struct packed {
        logic        valid;
        logic        done;
        logic [1:0]  mode;
        logic [31:0] requester;
        logic [30:0] handle;
        logic [31:0] friend_id;
        logic [31:0] mem;
        logic [30:0] id;
        logic [2:0]  status;
        logic [31:0] found;
    } oht_token_t;

endpackage

// ===== src/owned_handle_table.sv =====
// Top level of the owned handle table: request entry, cell row and result register.
//
//  channel   | ports                 | transaction
//  ----------+-----------------------+------------------------------------
//  request   | start, busy, req      | start high while busy low
//  result    | done, rsp             | done high for one cycle, no stall
//
//  A request passes one slot cell per cycle, through each cell register
//  and then the done register, which raises the result strobe; busy
//  stays high throughout. Busy falls at the edge that ends the strobe,
//  so the next request is accepted only after the previous result.
//  Reset frees all slots and clears the id generator at once.
//  The receiver cannot stall; the result is shown for one cycle only.
`timescale 1ns / 1ps

`include "owned_handle_table_macros.svh"

module owned_handle_table
    import oht_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  oht_req_t req,
    output logic     done,
    output oht_rsp_t rsp
);

    oht_token_t            chain [POOL_SLOTS+1];
    oht_token_t            entry;
    oht_token_t            tail;
    logic [POOL_SLOTS-1:0] cell_valid;
    logic                  accept;
    logic [30:0]           gen_reg, gen_next;
    logic [30:0]           gen_base;
    logic                  busy_reg, busy_next;
    logic                  done_reg;
    logic                  fail_shown;
    oht_rsp_t              rsp_reg, rsp_next;

    assign accept   = start && !busy_reg;
    assign gen_base = (gen_reg == ID_LIMIT) ? 31'd0 : gen_reg;
    assign gen_next = (accept && req.mode == MODE_CREATE) ? gen_base + 31'd1 : gen_reg;

    always_comb
    begin
        entry           = '0;
        entry.valid     = accept;
        entry.mode      = req.mode;
        entry.requester = req.requester_pid;
        entry.handle    = req.handle_id;
        entry.friend_id = req.guest_pid;
        entry.mem       = req.mem_ref;
        entry.id        = gen_base + 31'd1;
        entry.status    = ST_REFUSED;
        entry.found     = 32'd0;
        if (req.mode != MODE_CREATE && req.mode != MODE_DESTROY && req.mode != MODE_GET)
        begin
            entry.done = 1'b1;
        end
        else if (req.mode != MODE_CREATE && req.handle_id == 31'd0)
        begin
            entry.done   = 1'b1;
            entry.status = ST_NULL;
        end
    end

    assign chain[0] = entry;

    for (genvar i = 0; i < POOL_SLOTS; i++)
    begin : g_cell
        oht_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
        assign cell_valid[i] = chain[i+1].valid;
    end

    assign tail = chain[POOL_SLOTS];

    always_comb
    begin
        rsp_next               = '0;
        rsp_next.found_mem_ref = tail.found;
        if (tail.done)
        begin
            rsp_next.status = tail.status;
            if (tail.mode == MODE_CREATE)
            begin
                rsp_next.issued_id = tail.id;
            end
        end
        else
        begin
            rsp_next.status = (tail.mode == MODE_CREATE) ? ST_FULL : ST_MISSING;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (done_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg  <= 31'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            gen_reg  <= gen_next;
            busy_reg <= busy_next;
            done_reg <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    assign fail_shown = done_reg && rsp_reg.status != ST_OK;

    `OHT_ASSERT_NOW(a_done_in_busy, clk, rst_n, done_reg, busy_reg, "result outside a transaction")
    `OHT_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_reg, "busy not raised on accept")
    `OHT_ASSERT_NEXT(a_done_frees, clk, rst_n, done_reg, !busy_reg, "busy held after result")
    `OHT_ASSERT_NOW(a_one_token, clk, rst_n, 1'b1, $onehot0({cell_valid, done_reg}), "two in flight")
    `OHT_ASSERT_NOW(a_full_no_id, clk, rst_n, fail_shown, rsp_reg.issued_id == 31'd0, "id on failure")

endmodule

// ===== src/oht_cell.sv =====
// One slot of the handle table with its stage of the request token.
`timescale 1ns / 1ps

module oht_cell
    import oht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  oht_token_t tok_in,
    output oht_token_t tok_out
);

    oht_token_t  tok_reg, tok_next;
    logic [30:0] handle_reg, handle_next;
    logic [31:0] owner_reg, owner_next;
    logic [31:0] friend_reg, friend_next;
    logic [31:0] mem_reg, mem_next;

    always_comb
    begin
        tok_next    = tok_in;
        handle_next = handle_reg;
        owner_next  = owner_reg;
        friend_next = friend_reg;
        mem_next    = mem_reg;
        if (tok_in.valid && !tok_in.done)
        begin
            case (tok_in.mode)
                MODE_CREATE:
                begin
                    if (handle_reg == 31'd0)
                    begin
                        handle_next     = tok_in.id;
                        owner_next      = tok_in.requester;
                        friend_next     = tok_in.friend_id;
                        mem_next        = tok_in.mem;
                        tok_next.done   = 1'b1;
                        tok_next.status = ST_OK;
                    end
                end
                MODE_DESTROY:
                begin
                    if (handle_reg == tok_in.handle)
                    begin
                        tok_next.done = 1'b1;
                        if (owner_reg != tok_in.requester)
                        begin
                            tok_next.status = ST_REFUSED;
                        end
                        else
                        begin
                            handle_next     = 31'd0;
                            owner_next      = NO_OWNER;
                            friend_next     = NO_OWNER;
                            tok_next.status = ST_OK;
                        end
                    end
                end
                MODE_GET:
                begin
                    if (handle_reg == tok_in.handle)
                    begin
                        tok_next.done = 1'b1;
                        if (owner_reg != tok_in.requester && friend_reg != tok_in.requester)
                        begin
                            tok_next.status = ST_REFUSED;
                        end
                        else
                        begin
                            tok_next.found  = mem_reg;
                            tok_next.status = ST_OK;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            handle_reg <= 31'd0;
            owner_reg  <= NO_OWNER;
            friend_reg <= NO_OWNER;
            mem_reg    <= 32'd0;
        end
        else
        begin
            tok_reg    <= tok_next;
            handle_reg <= handle_next;
            owner_reg  <= owner_next;
            friend_reg <= friend_next;
            mem_reg    <= mem_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
